@@ rtl/ltc_pkg.sv @@
package ltc_pkg;

  // default longest lexeme that can still match a table word
  localparam int MAX_MATCH_LEN_DEF = 6;

  // longest word in any match table
  localparam int WORD_MAX = 6;
  localparam int WORD_LEN_W = 3;

  localparam int NUM_KEYWORDS = 7;
  localparam int NUM_OPERATORS = 11;
  localparam int NUM_PUNCTS = 8;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [WORD_LEN_W-1:0]     len;
    logic [0:WORD_MAX-1][7:0]  chars;
  } word_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_item_t;

  typedef struct packed {
    logic       is_identifier;
    logic       is_number;
    logic       is_string;
    logic [2:0] keyword_code;
    logic [3:0] operator_code;
    logic [3:0] punctuator_code;
  } result_item_t;

  localparam word_t KEYWORDS [NUM_KEYWORDS] = '{
    '{len: 3'd3, chars: {"i", "n", "t", CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd4, chars: {"m", "a", "i", "n", CH_NUL, CH_NUL}},
    '{len: 3'd4, chars: {"c", "h", "a", "r", CH_NUL, CH_NUL}},
    '{len: 3'd3, chars: {"f", "o", "r", CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd2, chars: {"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd4, chars: {"e", "l", "s", "e", CH_NUL, CH_NUL}},
    '{len: 3'd6, chars: {"r", "e", "t", "u", "r", "n"}}
  };

  localparam word_t OPERATORS [NUM_OPERATORS] = '{
    '{len: 3'd1, chars: {"=", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd2, chars: {"=", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd2, chars: {"!", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd2, chars: {">", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd2, chars: {"<", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {">", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"<", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"+", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"-", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"*", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"/", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}}
  };

  localparam word_t PUNCTS [NUM_PUNCTS] = '{
    '{len: 3'd1, chars: {"{", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"}", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {",", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {";", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"(", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {")", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"[", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}},
    '{len: 3'd1, chars: {"]", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}}
  };

endpackage

@@ rtl/ltc_char_if.sv @@
interface ltc_char_if;
  logic                   valid;
  logic                   ready;
  ltc_pkg::char_item_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ltc_result_if.sv @@
interface ltc_result_if;
  logic                   valid;
  logic                   ready;
  ltc_pkg::result_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lexeme_token_classifier.sv @@
// a closing character is staged in the input register, then its result in the result register
// throughput: one character per cycle; the input register and the result register
// are the only stages, so a result waiting downstream stalls only a closing character
// reset: synchronous active-high rst clears both valid flags and resets the running
// lexeme flags and count; the prefix buffer holds no reset and is only read where written
module lexeme_token_classifier #(
  parameter int MAX_MATCH_LEN = ltc_pkg::MAX_MATCH_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  ltc_char_if.sink            char_in,
  ltc_result_if.source        result_out
);

  // count saturates at MAX_MATCH_LEN + 1 so that longer lexemes never match
  localparam int COUNT_CAP = MAX_MATCH_LEN + 1;
  localparam int COUNT_W = $clog2(COUNT_CAP + 1);

  // input stage
  logic                     s1_valid;
  ltc_pkg::char_item_t      s1_item;
  logic                     s1_adv;

  // running lexeme state
  logic                     ident_ok, ident_ok_next;
  logic                     number_ok, number_ok_next;
  logic                     dot_seen, dot_seen_next;
  logic                     string_ok, string_ok_next;
  logic                     escape_pending, escape_pending_next;
  logic [COUNT_W-1:0]       char_count, char_count_next;
  logic [7:0]               prefix_chars [MAX_MATCH_LEN];
  logic [7:0]               prefix_chars_next [MAX_MATCH_LEN];

  // result stage
  logic                     res_valid;
  ltc_pkg::result_item_t    res_item;
  ltc_pkg::result_item_t    res_item_next;

  // character classes of the staged character
  logic [7:0]               ch;
  logic                     first, last;
  logic                     is_digit, is_alpha, is_dot, is_quote;
  logic                     is_str;

  // prefix widened to the longest table word for comparison
  logic [7:0]               match_chars [ltc_pkg::WORD_MAX];
  logic [2:0]               kw_code;
  logic [3:0]               op_code;
  logic [3:0]               pu_code;

  // a closing character must wait for a free result register, others flow on
  assign s1_adv = !s1_item.is_last || !res_valid || result_out.ready;
  assign char_in.ready = !s1_valid || s1_adv;

  assign result_out.valid = res_valid;
  assign result_out.data  = res_item;

  assign ch    = s1_item.char_code;
  assign last  = s1_item.is_last;
  assign first = (char_count == '0);

  assign is_digit = (ch >= "0") && (ch <= "9");
  assign is_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
  assign is_dot   = (ch == ltc_pkg::CH_DOT);
  assign is_quote = (ch == ltc_pkg::CH_QUOTE);

  // per-character flag updates
  always_comb begin
    if (first) begin
      ident_ok_next = ident_ok && (is_alpha || ch == ltc_pkg::CH_USCORE);
    end else begin
      ident_ok_next = ident_ok && (is_alpha || is_digit || ch == ltc_pkg::CH_USCORE);
    end

    number_ok_next = number_ok && !(first && !is_digit) && (is_digit || is_dot)
                     && !(is_dot && dot_seen) && !(last && !is_digit);
    dot_seen_next  = dot_seen || is_dot;

    // the opening quote is checked on the first character, inner quotes
    // only while the lexeme goes on; the closing one is judged below
    string_ok_next      = string_ok;
    escape_pending_next = escape_pending;
    if (first) begin
      string_ok_next = string_ok && is_quote;
    end else if (!last) begin
      if (!escape_pending && is_quote) begin
        string_ok_next = 1'b0;
      end
      escape_pending_next = escape_pending ? 1'b0 : (ch == ltc_pkg::CH_BSLASH);
    end
    is_str = string_ok_next && !first && !escape_pending && is_quote;

    if (char_count < COUNT_W'(COUNT_CAP)) begin
      char_count_next = char_count + COUNT_W'(1);
    end else begin
      char_count_next = char_count;
    end

    // one lane per prefix slot, written when the count points at it
    for (int k = 0; k < MAX_MATCH_LEN; k++) begin
      prefix_chars_next[k] = (char_count == COUNT_W'(k)) ? ch : prefix_chars[k];
    end
  end

  for (genvar k = 0; k < ltc_pkg::WORD_MAX; k++) begin : g_match_chars
    if (k < MAX_MATCH_LEN) begin : g_used
      assign match_chars[k] = prefix_chars_next[k];
    end else begin : g_pad
      assign match_chars[k] = ltc_pkg::CH_NUL;
    end
  end

  // exact-match compare against the constant tables; the lowest index wins
  always_comb begin
    logic hit;
    kw_code = '0;
    op_code = '0;
    pu_code = '0;

    for (int i = ltc_pkg::NUM_KEYWORDS - 1; i >= 0; i--) begin
      hit = (int'(ltc_pkg::KEYWORDS[i].len) <= MAX_MATCH_LEN)
            && (int'(char_count_next) == int'(ltc_pkg::KEYWORDS[i].len));
      for (int k = 0; k < ltc_pkg::WORD_MAX; k++) begin
        if (k < int'(ltc_pkg::KEYWORDS[i].len)) begin
          hit = hit && (match_chars[k] == ltc_pkg::KEYWORDS[i].chars[k]);
        end
      end
      if (hit) begin
        kw_code = 3'(i + 1);
      end
    end

    for (int i = ltc_pkg::NUM_OPERATORS - 1; i >= 0; i--) begin
      hit = (int'(ltc_pkg::OPERATORS[i].len) <= MAX_MATCH_LEN)
            && (int'(char_count_next) == int'(ltc_pkg::OPERATORS[i].len));
      for (int k = 0; k < ltc_pkg::WORD_MAX; k++) begin
        if (k < int'(ltc_pkg::OPERATORS[i].len)) begin
          hit = hit && (match_chars[k] == ltc_pkg::OPERATORS[i].chars[k]);
        end
      end
      if (hit) begin
        op_code = 4'(i + 1);
      end
    end

    for (int i = ltc_pkg::NUM_PUNCTS - 1; i >= 0; i--) begin
      hit = (int'(ltc_pkg::PUNCTS[i].len) <= MAX_MATCH_LEN)
            && (int'(char_count_next) == int'(ltc_pkg::PUNCTS[i].len));
      for (int k = 0; k < ltc_pkg::WORD_MAX; k++) begin
        if (k < int'(ltc_pkg::PUNCTS[i].len)) begin
          hit = hit && (match_chars[k] == ltc_pkg::PUNCTS[i].chars[k]);
        end
      end
      if (hit) begin
        pu_code = 4'(i + 1);
      end
    end
  end

  always_comb begin
    res_item_next.is_identifier   = ident_ok_next;
    res_item_next.is_number       = number_ok_next;
    res_item_next.is_string       = is_str;
    res_item_next.keyword_code    = kw_code;
    res_item_next.operator_code   = op_code;
    res_item_next.punctuator_code = pu_code;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      s1_item <= char_in.data;
    end
  end

  // lexeme state: a closing character puts everything back to its start value
  always_ff @(posedge clk) begin
    if (rst) begin
      ident_ok       <= 1'b1;
      number_ok      <= 1'b1;
      dot_seen       <= 1'b0;
      string_ok      <= 1'b1;
      escape_pending <= 1'b0;
      char_count     <= '0;
    end else if (s1_valid && s1_adv) begin
      if (last) begin
        ident_ok       <= 1'b1;
        number_ok      <= 1'b1;
        dot_seen       <= 1'b0;
        string_ok      <= 1'b1;
        escape_pending <= 1'b0;
        char_count     <= '0;
      end else begin
        ident_ok       <= ident_ok_next;
        number_ok      <= number_ok_next;
        dot_seen       <= dot_seen_next;
        string_ok      <= string_ok_next;
        escape_pending <= escape_pending_next;
        char_count     <= char_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      prefix_chars <= prefix_chars_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_adv && last) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv && last) begin
      res_item <= res_item_next;
    end
  end

endmodule

@@ tb/sv/tb_lexeme_token_classifier.sv @@
module tb_lexeme_token_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  // longest lexeme that can still match a table word
  localparam int MATCH_LEN = ltc_pkg::MAX_MATCH_LEN_DEF;
  // generous watchdog bound on the run
  localparam int unsigned CYCLE_LIMIT = 400000;
  // cycles to wait for stray results once nothing is expected
  localparam int SETTLE_CYCLES = 10;

  logic clk;
  logic rst;

  ltc_char_if   char_bus ();
  ltc_result_if res_bus ();

  lexeme_token_classifier #(
    .MAX_MATCH_LEN(MATCH_LEN)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_bus),
    .result_out(res_bus)
  );

  // 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // match tables, in code order (code = index + 1)
  string kw_words[$] = '{"int", "main", "char", "for", "if", "else", "return"};
  string op_words[$] = '{"=", "==", "!=", ">=", "<=", ">", "<", "+", "-", "*", "/"};
  string pn_words[$] = '{"{", "}", ",", ";", "(", ")", "[", "]"};

  // character pools for random lexemes
  string letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string digits    = "0123456789";
  string word_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string str_body  = "ab1 _x.\\\"";
  string symbols   = "=!<>+-*/{},;()[]\"\\._aZ09 ";

  // running state of the lexeme being classified
  bit          id_good;
  bit          num_good;
  bit          dot_found;
  bit          str_good;
  bit          esc_armed;
  int unsigned seen;
  logic [7:0]  head_buf [MATCH_LEN];

  // classification results still owed by the block, oldest first
  ltc_pkg::result_item_t expected_class_q[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned chars_sent;
  bit          idle_on;

  function automatic void clear_lexeme_state();
    id_good   = 1'b1;
    num_good  = 1'b1;
    dot_found = 1'b0;
    str_good  = 1'b1;
    esc_armed = 1'b0;
    seen      = 0;
    foreach (head_buf[k]) head_buf[k] = 8'h00;
  endfunction

  // 1-based index of the table word equal to the buffered head, or 0
  function automatic int unsigned lookup_word(input string words[$], input int unsigned len);
    bit same;
    for (int i = 0; i < words.size(); i++) begin
      if (words[i].len() == len && len <= MATCH_LEN) begin
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (words[i][k] != head_buf[k]) same = 1'b0;
        end
        if (same) return i + 1;
      end
    end
    return 0;
  endfunction

  // advance the running classification by one character; returns 1 with the
  // expected result when the character closes the lexeme
  function automatic bit classify_char(input logic [7:0] c, input bit last,
                                       output ltc_pkg::result_item_t res);
    bit first;
    bit digit;
    bit alpha;
    first = (seen == 0);
    digit = (c >= "0" && c <= "9");
    alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    res   = '0;

    // identifier: letter or underscore first, then word characters
    if (first) begin
      if (!(alpha || c == ltc_pkg::CH_USCORE)) id_good = 1'b0;
    end else if (!(alpha || digit || c == ltc_pkg::CH_USCORE)) begin
      id_good = 1'b0;
    end

    // number: digits, one dot at most, digit at both ends
    if (first && !digit) num_good = 1'b0;
    if (!(digit || c == ltc_pkg::CH_DOT)) num_good = 1'b0;
    if (c == ltc_pkg::CH_DOT) begin
      if (dot_found) num_good = 1'b0;
      dot_found = 1'b1;
    end
    if (last && !digit) num_good = 1'b0;

    // string: opening quote, no bare inner quote, closing quote not escaped
    if (first) begin
      if (c != ltc_pkg::CH_QUOTE) str_good = 1'b0;
    end else if (!last) begin
      if (!esc_armed && c == ltc_pkg::CH_QUOTE) str_good = 1'b0;
      esc_armed = esc_armed ? 1'b0 : (c == ltc_pkg::CH_BSLASH);
    end

    // head buffer and saturating length
    if (seen < MATCH_LEN) head_buf[seen] = c;
    if (seen < MATCH_LEN + 1) seen++;

    if (!last) return 1'b0;

    res.is_identifier   = id_good;
    res.is_number       = num_good;
    res.is_string       = str_good && !first && !esc_armed && c == ltc_pkg::CH_QUOTE;
    res.keyword_code    = 3'(lookup_word(kw_words, seen));
    res.operator_code   = 4'(lookup_word(op_words, seen));
    res.punctuator_code = 4'(lookup_word(pn_words, seen));
    clear_lexeme_state();
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // one character transaction; inputs move on the falling edge, acceptance
  // is seen on the rising edge
  task automatic send_char(input logic [7:0] c, input bit last);
    ltc_pkg::result_item_t res;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        char_bus.valid <= 1'b0;
      end
    end
    @(negedge clk);
    char_bus.valid <= 1'b1;
    char_bus.data  <= '{char_code: c, is_last: last};
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
    if (classify_char(c, last, res)) expected_class_q.push_back(res);
  endtask

  task automatic send_bytes(input logic [7:0] lex[$]);
    foreach (lex[k]) send_char(lex[k], k == lex.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_for_results();
    @(negedge clk);
    char_bus.valid <= 1'b0;
    while (expected_class_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp,
                             input int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  // every keyword, plus a bare prefix of one
  task automatic test_keywords();
    foreach (kw_words[i]) send_text(kw_words[i]);
    send_text("in");
  endtask

  // every operator and punctuator, single and double character
  task automatic test_operators_punctuators();
    foreach (op_words[i]) send_text(op_words[i]);
    foreach (pn_words[i]) send_text(pn_words[i]);
  endtask

  // identifier and number edges, and codes outside the letter range
  task automatic test_identifiers_numbers();
    send_text("_a9");
    send_text("Z");
    send_text("9x");
    send_text("3.14");
    send_text("1..2");
    send_text(".5");
    send_text("5.");
    send_text("0");
    send_bytes('{8'h00, 8'hFF});
    send_bytes('{8'h80, 8'h7F, 8'h61});
    send_bytes('{8'h61, 8'hC1});
  endtask

  // quoting, escapes and the lone quote
  task automatic test_strings();
    send_text("\"\"");
    send_text("\"");
    send_text("\"a\\\"b\"");
    send_text("\"a\\\"");
    send_text("\"a\"b\"");
    send_text("\"\\\\\"");
    send_text("\"ab");
  endtask

  // lexemes at and beyond the match length, including count saturation
  task automatic test_long_lexemes();
    send_text("return");
    send_text("returns");
    send_text("returnreturn");
    send_text("=========");
  endtask

  // mostly well-formed lexemes with random content, the rest near misses
  // and noise; idling stops for the final stretch
  task automatic test_random_lexemes(input int unsigned n_chars);
    logic [7:0]  lex[$];
    string       w;
    int unsigned target;
    int          n;
    int          r;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      if (chars_sent + 200 >= target) idle_on = 1'b0;
      lex.delete();
      case ($urandom_range(0, 9))
        0, 1: begin
          // identifier shape
          lex.push_back($urandom_range(0, 4) == 0 ? ltc_pkg::CH_USCORE : pick(letters));
          n = $urandom_range(0, 7);
          repeat (n) lex.push_back(pick(word_tail));
        end
        2: begin
          // number, sometimes with dots in awkward places
          n = $urandom_range(1, 6);
          repeat (n) lex.push_back(pick(digits));
          r = $urandom_range(0, 3);
          if (r == 1) lex.insert($urandom_range(0, lex.size()), ltc_pkg::CH_DOT);
          if (r == 2) begin
            lex.insert($urandom_range(0, lex.size()), ltc_pkg::CH_DOT);
            lex.insert($urandom_range(0, lex.size()), ltc_pkg::CH_DOT);
          end
          if (r == 3 && lex.size() > 1) begin
            lex.insert($urandom_range(1, lex.size() - 1), ltc_pkg::CH_DOT);
          end
        end
        3: begin
          // quoted text with escapes; closing quote sometimes missing or escaped
          lex.push_back(ltc_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) lex.push_back(pick(str_body));
          r = $urandom_range(0, 5);
          if (r == 1) lex.push_back(ltc_pkg::CH_BSLASH);
          if (r != 0) lex.push_back(ltc_pkg::CH_QUOTE);
        end
        4: begin
          // keyword, sometimes altered, extended or cut short
          w = kw_words[$urandom_range(0, kw_words.size() - 1)];
          for (int k = 0; k < w.len(); k++) lex.push_back(w[k]);
          r = $urandom_range(0, 3);
          if (r == 1) lex[$urandom_range(0, lex.size() - 1)] = pick(letters);
          if (r == 2) lex.push_back(pick(word_tail));
          if (r == 3) void'(lex.pop_back());
        end
        5: begin
          // table operator or punctuator
          w = $urandom_range(0, 1) ? op_words[$urandom_range(0, op_words.size() - 1)]
                                   : pn_words[$urandom_range(0, pn_words.size() - 1)];
          for (int k = 0; k < w.len(); k++) lex.push_back(w[k]);
        end
        6: begin
          // beyond the match length
          n = $urandom_range(7, 12);
          repeat (n) lex.push_back(pick(word_tail));
        end
        7: begin
          // raw bytes over the whole code range
          n = $urandom_range(1, 9);
          repeat (n) lex.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          // short symbol runs: chance hits on two-character operators
          n = $urandom_range(1, 3);
          repeat (n) lex.push_back(pick(symbols));
        end
      endcase
      if (lex.size() == 0) lex.push_back(pick(symbols));
      send_bytes(lex);
    end
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left    = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 15);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest owed classification
  always @(posedge clk) begin
    ltc_pkg::result_item_t exp;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_class_q.size() == 0) begin
        $error("result with nothing expected: %p", res_bus.data);
        errors++;
      end else begin
        exp = expected_class_q.pop_front();
        check_field("is_identifier", exp.is_identifier, res_bus.data.is_identifier);
        check_field("is_number", exp.is_number, res_bus.data.is_number);
        check_field("is_string", exp.is_string, res_bus.data.is_string);
        check_field("keyword_code", exp.keyword_code, res_bus.data.keyword_code);
        check_field("operator_code", exp.operator_code, res_bus.data.operator_code);
        check_field("punctuator_code", exp.punctuator_code, res_bus.data.punctuator_code);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.data  = '0;
    errors         = 0;
    cycles         = 0;
    chars_sent     = 0;
    idle_on        = 1'b1;
    clear_lexeme_state();

    // reset held at the start, released on a falling edge
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_keywords();
    wait_for_results();
    test_operators_punctuators();
    test_identifiers_numbers();
    wait_for_results();
    test_strings();
    test_long_lexemes();
    wait_for_results();
    test_random_lexemes(900);
    wait_for_results();

    // let any stray result surface
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ lexeme_token_classifier.f @@
rtl/ltc_pkg.sv
rtl/ltc_char_if.sv
rtl/ltc_result_if.sv
rtl/lexeme_token_classifier.sv
tb/sv/tb_lexeme_token_classifier.sv
